// ----- design/mmb_pkg.sv -----
`timescale 1ns / 1ps

package mmb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DUR_W       = 16;
    localparam int LEN_W       = 5;
    localparam int CHAR_W      = 7;
    localparam int SLOT_W      = 4;
    localparam int SLOTS       = 16;
    localparam int ELEM_W      = 3;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam logic [DUR_W-1:0] RST_DOT        = 16'd200;
    localparam logic [DUR_W-1:0] RST_DASH       = 16'd600;
    localparam logic [DUR_W-1:0] RST_LETTER_GAP = 16'd600;
    localparam logic [DUR_W-1:0] RST_WORD_GAP   = 16'd1400;
    localparam logic [LEN_W-1:0] RST_MSG_LEN    = 5'd11;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h5A;

    localparam int            BOOT_LEN  = 11;
    localparam logic [87:0]   BOOT_TEXT = "BOOTLOADER ";

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DOT        = 3'd0,
        REG_DASH       = 3'd1,
        REG_LETTER_GAP = 3'd2,
        REG_WORD_GAP   = 3'd3,
        REG_MSG_LEN    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]        pat;
        logic [ELEM_W-1:0] len;
    } t_code;

    // Element patterns hold the first element in the lowest bit, a one is a dash.
    localparam t_code LETTER_CODES [26] = '{
        '{5'h02, 3'd2}, '{5'h01, 3'd4}, '{5'h05, 3'd4}, '{5'h01, 3'd3},
        '{5'h00, 3'd1}, '{5'h04, 3'd4}, '{5'h03, 3'd3}, '{5'h00, 3'd4},
        '{5'h00, 3'd2}, '{5'h0E, 3'd4}, '{5'h05, 3'd3}, '{5'h02, 3'd4},
        '{5'h03, 3'd2}, '{5'h01, 3'd2}, '{5'h07, 3'd3}, '{5'h06, 3'd4},
        '{5'h0B, 3'd4}, '{5'h02, 3'd3}, '{5'h00, 3'd3}, '{5'h01, 3'd1},
        '{5'h04, 3'd3}, '{5'h08, 3'd4}, '{5'h06, 3'd3}, '{5'h09, 3'd4},
        '{5'h0D, 3'd4}, '{5'h03, 3'd4}
    };

    function automatic t_code code_of(input logic [CHAR_W-1:0] ch);
        t_code c;
        logic [CHAR_W-1:0] off;
        c   = '{5'h00, 3'd0};
        off = ch - CHAR_A;
        if (ch inside {[CHAR_A:CHAR_Z]}) begin
            c = LETTER_CODES[off[4:0]];
        end else begin
            case (ch)
                7'h30:   c = '{5'h1F, 3'd5};
                7'h31:   c = '{5'h1E, 3'd5};
                7'h32:   c = '{5'h1C, 3'd5};
                7'h33:   c = '{5'h18, 3'd5};
                7'h34:   c = '{5'h10, 3'd5};
                7'h35:   c = '{5'h00, 3'd5};
                7'h36:   c = '{5'h01, 3'd5};
                7'h37:   c = '{5'h03, 3'd5};
                7'h38:   c = '{5'h07, 3'd5};
                7'h39:   c = '{5'h0F, 3'd5};
                default: c = '{5'h00, 3'd0};
            endcase
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] boot_char(input int i);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (i < BOOT_LEN) begin
            c = BOOT_TEXT[8*(BOOT_LEN-1-i) +: CHAR_W];
        end
        return c;
    endfunction

endpackage

// ----- design/morse_message_beacon.sv -----
`timescale 1ns / 1ps

// Morse message beacon. Each beat on the slave stream is either one time tick
// (tuser 0) or a write of one message character (tuser 1). Every accepted beat
// yields exactly one result beat on the master stream with the LED level and
// the position of the character being sent, both as they stand after that beat.
// The message repeats after a word gap; characters without a code are skipped.
// A tick with busy_req set keeps the sequence where it is and shows the LED dark,
// while the elapsed counter still runs.
// Each result beat is held in the result register: the step logic sits between
// the input handshake and the result register. One beat is taken every cycle while
// the skid register is empty. A skid register behind the result register lets one
// more beat in while the receiver stalls; with both full, o_s_tready drops until a
// result beat leaves.
// The configuration channel is always ready and takes one register per beat; the user
// must write it only while the stream is idle, which the block itself does not enforce.
// After reset the message is "BOOTLOADER " with length 11 and the timing
// registers hold 200, 600, 600 and 1400 ticks.
module morse_message_beacon #(
    parameter int MESSAGE_DEPTH = 16,
    parameter int TIMER_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mmb_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields from bit 0: busy_req, char_index[3:0], char_code[6:0], zero fill.
    input  logic [mmb_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // Fields from bit 0: mode.
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0: led_on, char_position[4:0], zero fill.
    output logic [mmb_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int STORE_DEPTH = (MESSAGE_DEPTH < mmb_pkg::SLOTS) ? MESSAGE_DEPTH
                                                                  : mmb_pkg::SLOTS;
    localparam int SIW = $clog2(STORE_DEPTH);
    localparam int LW  = ($clog2(MESSAGE_DEPTH + 1) > mmb_pkg::LEN_W)
                         ? $clog2(MESSAGE_DEPTH + 1) : mmb_pkg::LEN_W;
    localparam int CW  = (TIMER_WIDTH > mmb_pkg::DUR_W) ? TIMER_WIDTH : mmb_pkg::DUR_W;

    logic [mmb_pkg::DUR_W-1:0]  r_dot, r_dash, r_letter_gap, r_word_gap;
    logic [mmb_pkg::LEN_W-1:0]  r_msg_len;
    logic [mmb_pkg::CHAR_W-1:0] r_store [STORE_DEPTH];
    logic [mmb_pkg::LEN_W-1:0]  r_ptr, n_ptr;
    logic [mmb_pkg::ELEM_W-1:0] r_ep, n_ep;
    logic                       r_lit, n_lit;
    logic [TIMER_WIDTH-1:0]     r_el, n_el;

    logic                            r_out_valid, r_skid_valid;
    logic [mmb_pkg::OUT_DATA_W-1:0]  r_out_data, r_skid_data;

    logic                        in_mode, in_busy, in_accept, out_take;
    logic [mmb_pkg::SLOT_W-1:0]  in_idx;
    logic [mmb_pkg::CHAR_W-1:0]  in_code, cur_ch;
    logic [LW-1:0]               eff_len;
    logic [TIMER_WIDTH-1:0]      el_inc;
    logic [CW-1:0]               el_cmp;
    mmb_pkg::t_code              cur_code;
    logic [mmb_pkg::DUR_W-1:0]   elem_dur;
    logic [mmb_pkg::OUT_DATA_W-1:0] res_data;
    logic                        store_we;

    assign in_busy = i_s_tdata[0];
    assign in_idx  = i_s_tdata[4:1];
    assign in_code = i_s_tdata[11:5];
    assign in_mode = i_s_tuser;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign out_take    = r_out_valid && i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign eff_len  = (LW'(r_msg_len) > LW'(MESSAGE_DEPTH)) ? LW'(MESSAGE_DEPTH)
                                                            : LW'(r_msg_len);
    assign cur_ch   = (LW'(r_ptr) < LW'(STORE_DEPTH)) ? r_store[r_ptr[SIW-1:0]] : '0;
    assign cur_code = mmb_pkg::code_of(cur_ch);
    assign el_inc   = (r_el == '1) ? r_el : TIMER_WIDTH'(r_el + 1'b1);
    assign el_cmp   = CW'(el_inc);
    assign elem_dur = ((cur_code.pat >> r_ep) & 5'd1) != 5'd0 ? r_dash : r_dot;
    assign store_we = in_accept && in_mode && (LW'(in_idx) < LW'(MESSAGE_DEPTH));

    always_comb begin
        n_ptr = r_ptr;
        n_ep  = r_ep;
        n_lit = r_lit;
        n_el  = r_el;
        if (!in_mode) begin
            n_el = el_inc;
            if (!in_busy) begin
                if (LW'(r_ptr) >= eff_len) begin
                    if (el_cmp >= CW'(r_word_gap)) begin
                        n_ptr = '0;
                        n_ep  = '0;
                        n_lit = 1'b0;
                        n_el  = '0;
                    end
                end else if (cur_ch == mmb_pkg::CHAR_SPACE || cur_code.len == '0
                             || r_ep >= cur_code.len) begin
                    if ((cur_ch == mmb_pkg::CHAR_SPACE && el_cmp >= CW'(r_word_gap))
                        || (cur_ch != mmb_pkg::CHAR_SPACE && cur_code.len == '0)
                        || (cur_ch != mmb_pkg::CHAR_SPACE && cur_code.len != '0
                            && el_cmp >= CW'(r_letter_gap))) begin
                        n_ptr = r_ptr + 1'b1;
                        n_ep  = '0;
                        n_lit = 1'b0;
                        n_el  = '0;
                    end
                end else if (!r_lit) begin
                    if (r_ep == '0 || el_cmp >= CW'(r_dot)) begin
                        n_lit = 1'b1;
                        n_el  = '0;
                    end
                end else if (el_cmp >= CW'(elem_dur)) begin
                    n_lit = 1'b0;
                    n_ep  = r_ep + 1'b1;
                    n_el  = '0;
                end
            end
        end
        res_data = {2'b00, n_ptr, n_lit && !in_busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot        <= mmb_pkg::RST_DOT;
            r_dash       <= mmb_pkg::RST_DASH;
            r_letter_gap <= mmb_pkg::RST_LETTER_GAP;
            r_word_gap   <= mmb_pkg::RST_WORD_GAP;
            r_msg_len    <= mmb_pkg::RST_MSG_LEN;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= mmb_pkg::boot_char(i);
            end
            r_ptr        <= '0;
            r_ep         <= '0;
            r_lit        <= 1'b0;
            r_el         <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mmb_pkg::REG_DOT:        r_dot        <= i_cfg_data;
                    mmb_pkg::REG_DASH:       r_dash       <= i_cfg_data;
                    mmb_pkg::REG_LETTER_GAP: r_letter_gap <= i_cfg_data;
                    mmb_pkg::REG_WORD_GAP:   r_word_gap   <= i_cfg_data;
                    mmb_pkg::REG_MSG_LEN:    r_msg_len    <= i_cfg_data[mmb_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (store_we) begin
                r_store[in_idx[SIW-1:0]] <= in_code;
            end
            if (in_accept) begin
                r_ptr <= n_ptr;
                r_ep  <= n_ep;
                r_lit <= n_lit;
                r_el  <= n_el;
            end
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_data  <= res_data;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_data  <= res_data;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/mmb_checker.sv -----
`timescale 1ns / 1ps

module mmb_assertions #(
    parameter int MESSAGE_DEPTH = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mmb_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int PW = ($clog2(MESSAGE_DEPTH + 1) > 6) ? $clog2(MESSAGE_DEPTH + 1) : 6;

    // A stalled result beat keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // After every accepted input beat, a result beat is valid on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted beat gave no result");

    // The position never runs past MESSAGE_DEPTH.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> PW'(o_m_tdata[5:1]) <= PW'(MESSAGE_DEPTH))
        else $error("char_position beyond message depth");

    // Input is only refused while a result waits on a stalled receiver.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input refused with no result pending");

endmodule

bind morse_message_beacon mmb_assertions #(.MESSAGE_DEPTH(MESSAGE_DEPTH)) u_mmb_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
